// ----- rtl/bta_pkg.sv -----
// Shared types and constants for the block table allocator.
// No dependencies; imported by every module of the block.
package bta_pkg;

  localparam int BLOCK_BYTES_DEF   = 32;
  localparam int TABLE_ENTRIES_DEF = 16;

  localparam int CMD_W   = 2;
  localparam int SIZE_W  = 16;
  localparam int OFF_W   = 16;
  localparam int STAT_W  = 2;
  localparam int AOFF_W  = 9;
  localparam int PCT_W   = 7;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK          = 2'd0;
  localparam logic [STAT_W-1:0] ST_ALLOC_FAIL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_OUT_OF_POOL = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic              load;     // capture a new item
    logic              scan;     // one step of the downward free-run scan
    logic              mark;     // write one entry of the claimed run
    logic              seek;     // one step of the offset-to-index search
    logic              rd_load;  // take the read entry as the clear count
    logic              clear;    // clear one entry
    logic              finish;   // latch the result
    logic [STAT_W-1:0] status;
  } bta_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_alloc;
    logic is_free;
    logic size_zero;
    logic off_out;
    logic match;
    logic scan_last;
    logic mark_last;
    logic seek_hit;
    logic clear_done;
  } bta_sts_t;

endpackage

// ----- rtl/bta_dp.sv -----
// Datapath of the block table allocator: table memory, occupancy bits,
// scan/mark/clear pointers, usage counter and result registers. Uses bta_pkg.
module bta_dp
  import bta_pkg::*;
#(
  parameter int BLOCK_BYTES   = BLOCK_BYTES_DEF,
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bta_cmd_t          cmd_i,
  output bta_sts_t          sts_o,
  input  logic [CMD_W-1:0]  cmd_in_i,
  input  logic [SIZE_W-1:0] alloc_size_i,
  input  logic [OFF_W-1:0]  free_offset_i,
  output logic [STAT_W-1:0] status_o,
  output logic [AOFF_W-1:0] alloc_offset_o,
  output logic [PCT_W-1:0]  usage_percent_o
);

  localparam int IW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW    = $clog2(TABLE_ENTRIES + 1);
  localparam int POOL  = BLOCK_BYTES * TABLE_ENTRIES;
  localparam int PW    = $clog2(POOL + BLOCK_BYTES + 1);
  localparam int CMPW  = (PW > SIZE_W) ? PW : SIZE_W;

  logic [CW-1:0]     mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] used_q;
  logic [CW-1:0]     cnt_q;

  logic [CMD_W-1:0]  cmd_q;
  logic [SIZE_W-1:0] size_q;
  logic [OFF_W-1:0]  off_q;

  logic [IW-1:0]     scan_idx_q;
  logic [CW-1:0]     run_q;
  logic [CMPW-1:0]   run_bytes_q;
  logic [CW-1:0]     need_q;
  logic [AOFF_W-1:0] aoff_q;

  logic [IW-1:0]     seek_idx_q;
  logic [CMPW-1:0]   base_q;

  logic [CW-1:0]     ptr_q;
  logic [CW-1:0]     remain_q;
  logic [CW-1:0]     rd_q;
  logic              rd_used_q;

  logic [STAT_W-1:0] res_status_q;
  logic [AOFF_W-1:0] res_aoff_q;
  logic [PCT_W-1:0]  res_pct_q;

  logic [PCT_W-1:0]  pct_tab [TABLE_ENTRIES+1];

  logic              scan_free;
  logic [CMPW-1:0]   run_bytes_nx;
  logic [CMPW-1:0]   base_nx;
  logic [CMPW-1:0]   scan_off;
  logic [IW-1:0]     ptr_idx;

  // usage percentage per used-entry count, worked out at elaboration
  for (genvar g = 0; g <= TABLE_ENTRIES; g++) begin : g_pct
    assign pct_tab[g] = PCT_W'((g * 100) / TABLE_ENTRIES);
  end

  assign ptr_idx      = ptr_q[IW-1:0];
  assign scan_free    = ~used_q[scan_idx_q];
  assign run_bytes_nx = run_bytes_q + CMPW'(BLOCK_BYTES);
  assign base_nx      = base_q + CMPW'(BLOCK_BYTES);
  assign scan_off     = CMPW'(scan_idx_q) * CMPW'(BLOCK_BYTES);

  always_comb begin
    sts_o.is_alloc   = (cmd_q == CMD_ALLOC);
    sts_o.is_free    = (cmd_q == CMD_FREE);
    sts_o.size_zero  = (size_q == '0);
    sts_o.off_out    = (CMPW'(off_q) >= CMPW'(POOL));
    // first free entry that brings the run to the requested bytes ends the search
    sts_o.match      = scan_free && (run_bytes_nx >= CMPW'(size_q));
    sts_o.scan_last  = (scan_idx_q == '0);
    sts_o.mark_last  = (remain_q == CW'(1));
    sts_o.seek_hit   = (base_nx > CMPW'(off_q));
    sts_o.clear_done = (remain_q == '0) || (ptr_q == CW'(TABLE_ENTRIES));
  end

  // run lengths; only used for entries whose occupancy bit is set
  always_ff @(posedge clk_i) begin
    if (cmd_i.mark) begin
      mem[ptr_idx] <= need_q;
    end
    if (cmd_i.seek && sts_o.seek_hit) begin
      rd_q <= mem[seek_idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q       <= '0;
      cnt_q        <= '0;
      res_status_q <= ST_OK;
      res_aoff_q   <= '0;
      res_pct_q    <= '0;
    end else begin
      if (cmd_i.mark) begin
        used_q[ptr_idx] <= 1'b1;
        cnt_q           <= cnt_q + CW'(1);
      end else if (cmd_i.clear) begin
        used_q[ptr_idx] <= 1'b0;
        if (used_q[ptr_idx]) begin
          cnt_q <= cnt_q - CW'(1);
        end
      end
      if (cmd_i.finish) begin
        res_status_q <= cmd_i.status;
        res_aoff_q   <= aoff_q;
        res_pct_q    <= pct_tab[cnt_q];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q       <= cmd_in_i;
      size_q      <= alloc_size_i;
      off_q       <= free_offset_i;
      scan_idx_q  <= IW'(TABLE_ENTRIES - 1);
      run_q       <= '0;
      run_bytes_q <= '0;
      aoff_q      <= '0;
      seek_idx_q  <= '0;
      base_q      <= '0;
    end
    if (cmd_i.scan) begin
      if (sts_o.match) begin
        ptr_q    <= CW'(scan_idx_q);
        remain_q <= run_q + CW'(1);
        need_q   <= run_q + CW'(1);
        aoff_q   <= scan_off[AOFF_W-1:0];
      end else begin
        scan_idx_q <= scan_idx_q - IW'(1);
      end
      if (scan_free) begin
        run_q       <= run_q + CW'(1);
        run_bytes_q <= run_bytes_nx;
      end else begin
        run_q       <= '0;
        run_bytes_q <= '0;
      end
    end
    if (cmd_i.seek) begin
      if (sts_o.seek_hit) begin
        ptr_q     <= CW'(seek_idx_q);
        rd_used_q <= used_q[seek_idx_q];
      end else begin
        base_q     <= base_nx;
        seek_idx_q <= seek_idx_q + IW'(1);
      end
    end
    if (cmd_i.rd_load) begin
      remain_q <= rd_used_q ? rd_q : '0;
    end
    if (cmd_i.mark || cmd_i.clear) begin
      ptr_q    <= ptr_q + CW'(1);
      remain_q <= remain_q - CW'(1);
    end
  end

  assign status_o        = res_status_q;
  assign alloc_offset_o  = res_aoff_q;
  assign usage_percent_o = res_pct_q;

endmodule

// ----- rtl/bta_ctrl.sv -----
// Controller of the block table allocator: sequences scan, mark, seek and
// clear steps of the datapath. Uses bta_pkg command/status structs.
module bta_ctrl
  import bta_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  output logic     done_o,
  output bta_cmd_t cmd_o,
  input  bta_sts_t sts_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_MARK,
    S_SEEK,
    S_RDWAIT,
    S_CLEAR,
    S_FINISH
  } state_e;

  state_e            state_q, state_d;
  logic [STAT_W-1:0] stat_q, stat_d;
  logic              done_q;

  always_comb begin
    state_d = state_q;
    stat_d  = stat_q;
    cmd_o   = '0;
    cmd_o.status = stat_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        stat_d = ST_OK;
        if (sts_i.is_alloc) begin
          if (sts_i.size_zero) begin
            stat_d  = ST_ALLOC_FAIL;
            state_d = S_FINISH;
          end else begin
            state_d = S_SCAN;
          end
        end else if (sts_i.is_free) begin
          if (sts_i.off_out) begin
            stat_d  = ST_OUT_OF_POOL;
            state_d = S_FINISH;
          end else begin
            state_d = S_SEEK;
          end
        end else begin
          state_d = S_FINISH;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.match) begin
          state_d = S_MARK;
        end else if (sts_i.scan_last) begin
          stat_d  = ST_ALLOC_FAIL;
          state_d = S_FINISH;
        end
      end
      S_MARK: begin
        cmd_o.mark = 1'b1;
        if (sts_i.mark_last) begin
          state_d = S_FINISH;
        end
      end
      S_SEEK: begin
        cmd_o.seek = 1'b1;
        if (sts_i.seek_hit) begin
          state_d = S_RDWAIT;
        end
      end
      S_RDWAIT: begin
        cmd_o.rd_load = 1'b1;
        state_d       = S_CLEAR;
      end
      S_CLEAR: begin
        if (sts_i.clear_done) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.clear = 1'b1;
        end
      end
      S_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      stat_q  <= ST_OK;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      stat_q  <= stat_d;
      done_q  <= (state_q == S_FINISH);
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

// ----- rtl/block_table_allocator_top.sv -----
// channel   | handshake        | payload
// ----------+------------------+----------------------------------------------
// command   | start / busy     | cmd_i, alloc_size_i, free_offset_i
// result    | done_o (strobe)  | status_o, alloc_offset_o, usage_percent_o
//
// An item is taken when start is high and busy is low; one result follows.
// Query or rejected item: dispatch, then finish; done_o follows finish.
// Allocate: the downward scan from the top tests one table entry per cycle,
// then the claimed run is written one entry per cycle. Free: a search up to
// the block index, a read of its run count, then entries cleared, one per cycle.
// Reset clears the occupancy bits at once; done_o is a one-cycle pulse that
// the receiver must take, busy stays high until the result is out.
// Top level of the block table allocator. Depends on bta_pkg, bta_ctrl, bta_dp.
module block_table_allocator_top
  import bta_pkg::*;
#(
  parameter int BLOCK_BYTES   = BLOCK_BYTES_DEF,
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [CMD_W-1:0]  cmd_i,
  input  logic [SIZE_W-1:0] alloc_size_i,
  input  logic [OFF_W-1:0]  free_offset_i,
  output logic              done_o,
  output logic [STAT_W-1:0] status_o,
  output logic [AOFF_W-1:0] alloc_offset_o,
  output logic [PCT_W-1:0]  usage_percent_o
);

  bta_cmd_t cmd;
  bta_sts_t sts;

  bta_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd),
    .sts_i  (sts)
  );

  bta_dp #(
    .BLOCK_BYTES   (BLOCK_BYTES),
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cmd_in_i        (cmd_i),
    .alloc_size_i    (alloc_size_i),
    .free_offset_i   (free_offset_i),
    .status_o        (status_o),
    .alloc_offset_o  (alloc_offset_o),
    .usage_percent_o (usage_percent_o)
  );

endmodule

// ----- rtl/bta_checker.sv -----
// Port-level checks for the block table allocator, bound to the top level.
// Uses bta_pkg status codes and field widths.
module bta_checker
  import bta_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              done_o,
  input logic [STAT_W-1:0] status_o,
  input logic [AOFF_W-1:0] alloc_offset_o,
  input logic [PCT_W-1:0]  usage_percent_o
);

  // an accepted item raises busy, which stays high until its result
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // only a successful allocate reports an offset
  a_fail_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> (alloc_offset_o == '0))
    else $error("offset reported on a failed item");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (usage_percent_o <= PCT_W'(100)))
    else $error("usage above 100 percent");

endmodule

bind block_table_allocator_top bta_checker u_bta_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .done_o          (done_o),
  .status_o        (status_o),
  .alloc_offset_o  (alloc_offset_o),
  .usage_percent_o (usage_percent_o)
);

// ----- tb/block_table_allocator_checker.sv -----
`timescale 1ns / 1ps
// Checker for the block table allocator: mirrors the block table, predicts each result
// and compares it with what the block returns. Depends on bta_pkg.
module block_table_allocator_checker
  import bta_pkg::*;
#(
  parameter int BLOCK_BYTES   = BLOCK_BYTES_DEF,
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  logic [CMD_W-1:0]  cmd_i,
  input  logic [SIZE_W-1:0] alloc_size_i,
  input  logic [OFF_W-1:0]  free_offset_i,
  input  logic              done_i,
  input  logic [STAT_W-1:0] status_i,
  input  logic [AOFF_W-1:0] alloc_offset_i,
  input  logic [PCT_W-1:0]  usage_percent_i,
  output int                mismatch_count_o,
  output int                outstanding_o,
  output int                granted_o,
  output int                refused_o,
  output int                frees_o,
  output int                queries_o,
  output int                peak_usage_o
);

  localparam int ENTRY_W    = 5;
  localparam int POOL_BYTES = BLOCK_BYTES * TABLE_ENTRIES;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [AOFF_W-1:0] alloc_offset;
    logic [PCT_W-1:0]  usage;
  } alloc_result_t;

  // zero = free block, otherwise length of the run the block belongs to
  logic [ENTRY_W-1:0] run_table [TABLE_ENTRIES];
  alloc_result_t      pending_results [$];
  alloc_result_t      want, got;

  initial begin
    mismatch_count_o = 0;
    granted_o        = 0;
    refused_o        = 0;
    frees_o          = 0;
    queries_o        = 0;
    peak_usage_o     = 0;
  end

  task automatic predict_result(input logic [CMD_W-1:0] cmd, input logic [SIZE_W-1:0] size,
                                input logic [OFF_W-1:0] off, output alloc_result_t res);
    int  need, run, k, j, idx, cnt, used;
    bit  found;
    res.status       = ST_OK;
    res.alloc_offset = '0;
    if (cmd == CMD_ALLOC) begin
      need  = (int'(size) + BLOCK_BYTES - 1) / BLOCK_BYTES;
      found = 1'b0;
      run   = 0;
      if (size != '0 && need <= TABLE_ENTRIES) begin
        // downward scan; the first run long enough wins
        for (k = TABLE_ENTRIES - 1; k >= 0; k--) begin
          if (!found) begin
            run = (run_table[k] == '0) ? run + 1 : 0;
            if (run == need) begin
              found = 1'b1;
              for (j = 0; j < need; j++) run_table[k + j] = ENTRY_W'(need);
              res.alloc_offset = AOFF_W'(k * BLOCK_BYTES);
            end
          end
        end
      end
      if (!found) res.status = ST_ALLOC_FAIL;
    end else if (cmd == CMD_FREE) begin
      if (int'(off) >= POOL_BYTES) begin
        res.status = ST_OUT_OF_POOL;
      end else begin
        idx = int'(off) / BLOCK_BYTES;
        cnt = int'(run_table[idx]);
        // clears the count held at the start block, clipped at the table end
        for (j = 0; j < cnt && idx + j < TABLE_ENTRIES; j++) run_table[idx + j] = '0;
      end
    end
    used = 0;
    for (k = 0; k < TABLE_ENTRIES; k++) if (run_table[k] != '0) used++;
    res.usage = PCT_W'(used * 100 / TABLE_ENTRIES);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int e = 0; e < TABLE_ENTRIES; e++) run_table[e] = '0;
      pending_results.delete();
      outstanding_o <= 0;
    end else begin
      if (done_i) begin
        got = '{status_i, alloc_offset_i, usage_percent_i};
        if (pending_results.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= REPORT_MAX)
            $display("%0t: result with no item pending: status %0d offset %0d usage %0d",
                     $realtime, got.status, got.alloc_offset, got.usage);
        end else begin
          want = pending_results.pop_front();
          if (want !== got) begin
            mismatch_count_o++;
            if (mismatch_count_o <= REPORT_MAX)
              $display({"%0t: result mismatch: expected status %0d offset %0d usage %0d,",
                        " got status %0d offset %0d usage %0d"}, $realtime,
                       want.status, want.alloc_offset, want.usage,
                       got.status, got.alloc_offset, got.usage);
          end
        end
      end
      if (start_i && !busy_i) begin
        predict_result(cmd_i, alloc_size_i, free_offset_i, want);
        pending_results.push_back(want);
        if (cmd_i == CMD_ALLOC) begin
          if (want.status == ST_OK) granted_o++;
          else refused_o++;
        end else if (cmd_i == CMD_FREE) begin
          frees_o++;
        end else begin
          queries_o++;
        end
        if (int'(want.usage) > peak_usage_o) peak_usage_o = int'(want.usage);
      end
      outstanding_o <= pending_results.size();
    end
  end

endmodule

// ----- tb/tb_block_table_allocator_top.sv -----
`timescale 1ns / 1ps
// Top of the block table allocator testbench: clock, reset, directed and random commands,
// watchdog and verdict. Depends on bta_pkg, block_table_allocator_top and the checker.
module tb_block_table_allocator_top;
  import bta_pkg::*;

  localparam int BLOCK_BYTES    = BLOCK_BYTES_DEF;
  localparam int TABLE_ENTRIES  = TABLE_ENTRIES_DEF;
  localparam int POOL_BYTES     = BLOCK_BYTES * TABLE_ENTRIES;
  localparam int RANDOM_ITEMS   = 2000;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int END_DRAIN      = 60;

  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [CMD_W-1:0]  cmd_i;
  logic [SIZE_W-1:0] alloc_size_i;
  logic [OFF_W-1:0]  free_offset_i;
  logic              done_o;
  logic [STAT_W-1:0] status_o;
  logic [AOFF_W-1:0] alloc_offset_o;
  logic [PCT_W-1:0]  usage_percent_o;

  int mismatch_count, outstanding, granted, refused, frees, queries, peak_usage;

  block_table_allocator_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .alloc_size_i   (alloc_size_i),
    .free_offset_i  (free_offset_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .alloc_offset_o (alloc_offset_o),
    .usage_percent_o(usage_percent_o)
  );

  block_table_allocator_checker #(
    .BLOCK_BYTES  (BLOCK_BYTES),
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_i          (busy),
    .cmd_i           (cmd_i),
    .alloc_size_i    (alloc_size_i),
    .free_offset_i   (free_offset_i),
    .done_i          (done_o),
    .status_i        (status_o),
    .alloc_offset_i  (alloc_offset_o),
    .usage_percent_i (usage_percent_o),
    .mismatch_count_o(mismatch_count),
    .outstanding_o   (outstanding),
    .granted_o       (granted),
    .refused_o       (refused),
    .frees_o         (frees),
    .queries_o       (queries),
    .peak_usage_o    (peak_usage)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Returns at the edge where the item is taken; start stays high so the next
  // item can follow without a bubble.
  task automatic issue_item(input logic [CMD_W-1:0] cmd, input logic [SIZE_W-1:0] size,
                            input logic [OFF_W-1:0] off, input bit may_idle);
    if (may_idle && $urandom_range(0, 99) < 25) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
    end
    start         <= 1'b1;
    cmd_i         <= cmd;
    alloc_size_i  <= size;
    free_offset_i <= off;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (start && !busy) || done_o) quiet = 0;
      else quiet++;
    end
    $display("Watchdog: nothing moved for %0d cycles, %0d results still due",
             WATCHDOG_LIMIT, outstanding);
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    int                n, r, pick;
    bit                idle_ok;
    logic [CMD_W-1:0]  c;
    logic [SIZE_W-1:0] sz;
    logic [OFF_W-1:0]  off;

    rst_ni        = 1'b0;
    start         = 1'b0;
    cmd_i         = CMD_ALLOC;
    alloc_size_i  = '0;
    free_offset_i = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: queries, refused sizes, full table, out-of-pool and odd frees
    issue_item(CMD_QUERY,  16'hFFFF, 16'hFFFF, 1'b1);
    issue_item(CMD_UNUSED, 16'h0000, 16'h0000, 1'b1);
    issue_item(CMD_ALLOC,  16'd0, 16'h5A5A, 1'b1);
    issue_item(CMD_ALLOC,  16'hFFFF, 16'd0, 1'b1);
    issue_item(CMD_ALLOC,  16'(POOL_BYTES + 1), 16'd0, 1'b1);
    issue_item(CMD_ALLOC,  16'(POOL_BYTES), 16'd0, 1'b1);          // whole table
    issue_item(CMD_ALLOC,  16'd1, 16'd0, 1'b1);                    // no room left
    issue_item(CMD_FREE,   16'd0, 16'(POOL_BYTES), 1'b1);
    issue_item(CMD_FREE,   16'hFFFF, 16'hFFFF, 1'b1);
    issue_item(CMD_FREE,   16'd0, 16'd0, 1'b1);                    // frees all
    issue_item(CMD_FREE,   16'd0, 16'd0, 1'b1);                    // already free
    issue_item(CMD_ALLOC,  16'(3 * BLOCK_BYTES), 16'd0, 1'b1);     // top three blocks
    // mid-run free: clear count runs off the table end
    issue_item(CMD_FREE,   16'd0, 16'((TABLE_ENTRIES - 2) * BLOCK_BYTES + 5), 1'b1);
    issue_item(CMD_ALLOC,  16'd1, 16'd0, 1'b1);
    issue_item(CMD_ALLOC,  16'(BLOCK_BYTES + 1), 16'd0, 1'b1);
    // clears past the end of its own run into a neighbor
    issue_item(CMD_FREE,   16'd0, 16'((TABLE_ENTRIES - 3) * BLOCK_BYTES), 1'b1);
    issue_item(CMD_ALLOC,  16'(POOL_BYTES - BLOCK_BYTES), 16'd0, 1'b1);
    issue_item(CMD_ALLOC,  16'((TABLE_ENTRIES - 5) * BLOCK_BYTES), 16'd0, 1'b1);
    issue_item(CMD_FREE,   16'd0, 16'((TABLE_ENTRIES - 5) * BLOCK_BYTES + 31), 1'b1);
    issue_item(CMD_ALLOC,  16'h8000, 16'h8000, 1'b1);
    issue_item(CMD_QUERY,  16'h7FFF, 16'h7FFF, 1'b1);
    issue_item(CMD_FREE,   16'd0, 16'(POOL_BYTES - 1), 1'b1);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      idle_ok = !(n >= 1000 && n < 1400);   // a stretch back to back
      r       = $urandom_range(0, 99);
      pick    = $urandom_range(0, 19);
      sz      = 16'($urandom);
      off     = 16'($urandom);
      if (r < 45) begin
        c = CMD_ALLOC;
        if (pick == 0) sz = '0;
        else if (pick <= 4) sz = 16'($urandom_range(1, POOL_BYTES));
        else if (pick > 5) sz = 16'($urandom_range(1, 4 * BLOCK_BYTES));
      end else if (r < 85) begin
        c = CMD_FREE;
        if (pick == 1) off = 16'($urandom_range(POOL_BYTES, 2 * POOL_BYTES));
        else if (pick <= 5)
          off = 16'($urandom_range(0, TABLE_ENTRIES - 1) * BLOCK_BYTES
                    + $urandom_range(0, BLOCK_BYTES - 1));
        else if (pick > 5) off = 16'($urandom_range(0, TABLE_ENTRIES - 1) * BLOCK_BYTES);
      end else begin
        c = (r < 95) ? CMD_QUERY : CMD_UNUSED;
      end
      issue_item(c, sz, off, idle_ok);
    end
    start <= 1'b0;

    while (outstanding != 0) @(negedge clk_i);
    repeat (END_DRAIN) @(posedge clk_i);

    $display("Covered %0d allocations granted, %0d refused, %0d frees, %0d queries",
             granted, refused, frees, queries);
    $display("Peak table usage %0d percent, %0d mismatching results", peak_usage,
             mismatch_count);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
